// ===== design/hsc_pkg.sv =====
// ----------------------------------------------------------------------------
// hsc_pkg
// Shared types, codes and helpers for the Hamming SEC codec.
// ----------------------------------------------------------------------------
package hsc_pkg;

    // width of code length / syndrome values (positions 1..63)
    localparam int LEN_W = 6;

    // operation codes carried on func
    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    // data_len after reset
    localparam logic [LEN_W-1:0] DATA_LEN_RST = 6'd57;

    // per-request control carried from front to back
    typedef struct packed {
        logic             func;
        logic [LEN_W-1:0] code_len;
    } t_ctl;

    // d + p, where p is the least count with 2^p >= d + p + 1
    function automatic logic [LEN_W:0] f_code_len(input logic [LEN_W-1:0] d);
        logic [2:0] p;
        logic       found;
        p     = 3'd0;
        found = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!found && ((9'd1 << i) >= (9'(d) + 9'(i) + 9'd1))) begin
                p     = 3'(i);
                found = 1'b1;
            end
        end
        return 7'(d) + 7'(p);
    endfunction

endpackage

// ===== design/hamming_sec_codec_core.sv =====
// ----------------------------------------------------------------------------
// hamming_sec_codec_core
// Single-error-correcting Hamming encoder / decoder with queue handshakes.
// ----------------------------------------------------------------------------
// Takes one request per clock (push while full is low) and returns one
// result per request, in order, on an empty/pop queue face. func 0 encodes
// data_word into a code word with data at the non-power-of-two positions
// and even parity at positions 1, 2, 4, ...; func 1 computes the syndrome
// of code_word, flips the named position and reports it, or flags
// bad_syndrome when the syndrome lies past the code length. The code length
// follows data_len (write with i_cfg_we; 0 acts as 1, values above the
// data width clamp). A pushed request is written into the two-entry
// request queue, then into the result register, where it sits until
// popped. Sustained rate is one request per cycle while results are
// popped, set by the queue and result register handshake; the syndrome
// is a single XOR tree per bit.
// Write data_len only while no request is in flight.
// ----------------------------------------------------------------------------
module hamming_sec_codec_core #(
    parameter int MAX_DATA_BITS = 57,
    parameter int MAX_CODE_BITS = 63
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration: data_len
    input  logic                        i_cfg_we,
    input  logic [hsc_pkg::LEN_W-1:0]   i_cfg_data,
    // request side
    input  logic                        push,
    output logic                        full,
    input  logic                        i_func,
    input  logic [MAX_DATA_BITS-1:0]    i_data_word,
    input  logic [MAX_CODE_BITS-1:0]    i_code_word,
    // result side
    output logic                        empty,
    input  logic                        pop,
    output logic [MAX_CODE_BITS-1:0]    o_code_out,
    output logic [hsc_pkg::LEN_W-1:0]   o_syndrome,
    output logic                        o_error_fixed,
    output logic                        o_bad_syndrome
);
    import hsc_pkg::*;

    // front -> queue
    logic [MAX_CODE_BITS-1:0] f_word;
    t_ctl                     f_ctl;
    // queue -> back
    logic [MAX_CODE_BITS-1:0] q_word;
    t_ctl                     q_ctl;
    logic                     q_empty;
    logic                     q_pop;

    // front: config register, code length, data layout / input masking
    hsc_front #(
        .MAX_DATA_BITS (MAX_DATA_BITS),
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_func      (i_func),
        .i_data_word (i_data_word),
        .i_code_word (i_code_word),
        .o_word      (f_word),
        .o_ctl       (f_ctl)
    );

    // decoupling queue; full here is the request-side backpressure
    hsc_queue #(
        .CODE_W (MAX_CODE_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (f_word),
        .i_ctl   (f_ctl),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_word  (q_word),
        .o_ctl   (q_ctl)
    );

    // back: syndrome, parity fill or repair, result register
    hsc_back #(
        .CODE_W (MAX_CODE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_word         (q_word),
        .i_ctl          (q_ctl),
        .o_q_pop        (q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_code_out     (o_code_out),
        .o_syndrome     (o_syndrome),
        .o_error_fixed  (o_error_fixed),
        .o_bad_syndrome (o_bad_syndrome)
    );

endmodule

// ===== design/hsc_front.sv =====
// ----------------------------------------------------------------------------
// hsc_front
// Holds data_len, derives the code length and lays out the request word.
// ----------------------------------------------------------------------------
module hsc_front #(
    parameter int MAX_DATA_BITS = 57,
    parameter int MAX_CODE_BITS = 63
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [hsc_pkg::LEN_W-1:0]   i_cfg_data,
    input  logic                        i_func,
    input  logic [MAX_DATA_BITS-1:0]    i_data_word,
    input  logic [MAX_CODE_BITS-1:0]    i_code_word,
    output logic [MAX_CODE_BITS-1:0]    o_word,
    output hsc_pkg::t_ctl               o_ctl
);
    import hsc_pkg::*;

    localparam logic [LEN_W-1:0] MAX_D = LEN_W'(MAX_DATA_BITS);
    localparam logic [LEN_W:0]   MAX_N = (LEN_W + 1)'(MAX_CODE_BITS);

    logic [LEN_W-1:0]         r_data_len;
    logic [LEN_W-1:0]         d_eff;
    logic [LEN_W:0]           n_raw;
    logic [LEN_W:0]           n_eff;
    logic [MAX_CODE_BITS-1:0] enc_word;
    logic [MAX_CODE_BITS-1:0] dec_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_len <= DATA_LEN_RST;
        end else if (i_cfg_we) begin
            r_data_len <= i_cfg_data;
        end
    end

    // clamp data length to 1..MAX_DATA_BITS, code length to MAX_CODE_BITS
    always_comb begin
        d_eff = r_data_len;
        if (d_eff == '0) begin
            d_eff = LEN_W'(1);
        end
        if (d_eff > MAX_D) begin
            d_eff = MAX_D;
        end
        n_raw = f_code_len(d_eff);
        n_eff = (n_raw > MAX_N) ? MAX_N : n_raw;
    end

    // data bit j sits at the j-th position that is not a power of two
    for (genvar k = 0; k < MAX_CODE_BITS; k++) begin : g_pos
        localparam int POS   = k + 1;
        localparam int J     = POS - $clog2(POS + 1) - 1;
        localparam bit IS_P2 = (POS & (POS - 1)) == 0;
        logic in_code;
        assign in_code = (7'(POS) <= n_eff);
        if (!IS_P2 && (J < MAX_DATA_BITS)) begin : g_data
            assign enc_word[k] = in_code && (7'(J) < 7'(d_eff)) && i_data_word[J];
        end else begin : g_par
            assign enc_word[k] = 1'b0;
        end
        assign dec_word[k] = in_code && i_code_word[k];
    end

    assign o_word         = (i_func == FUNC_DECODE) ? dec_word : enc_word;
    assign o_ctl.func     = i_func;
    assign o_ctl.code_len = n_eff[LEN_W-1:0];

endmodule

// ===== design/hsc_queue.sv =====
// ----------------------------------------------------------------------------
// hsc_queue
// Two-entry request queue between front and back.
// ----------------------------------------------------------------------------
module hsc_queue #(
    parameter int CODE_W = 63
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [CODE_W-1:0]   i_word,
    input  hsc_pkg::t_ctl       i_ctl,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [CODE_W-1:0]   o_word,
    output hsc_pkg::t_ctl       o_ctl
);
    import hsc_pkg::*;

    logic [CODE_W-1:0] r_word [2];
    t_ctl              r_ctl  [2];
    logic              r_wr_ptr, n_wr_ptr;
    logic              r_rd_ptr, n_rd_ptr;
    logic [1:0]        r_count,  n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = do_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = do_pop  ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_word[r_wr_ptr] <= i_word;
            r_ctl[r_wr_ptr]  <= i_ctl;
        end
    end

    assign o_word = r_word[r_rd_ptr];
    assign o_ctl  = r_ctl[r_rd_ptr];

endmodule

// ===== design/hsc_back.sv =====
// ----------------------------------------------------------------------------
// hsc_back
// Syndrome, parity insertion or single-bit repair, and the result register.
// ----------------------------------------------------------------------------
module hsc_back #(
    parameter int CODE_W = 63
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_empty,
    input  logic [CODE_W-1:0]           i_word,
    input  hsc_pkg::t_ctl               i_ctl,
    output logic                        o_q_pop,
    input  logic                        i_pop,
    output logic                        o_empty,
    output logic [CODE_W-1:0]           o_code_out,
    output logic [hsc_pkg::LEN_W-1:0]   o_syndrome,
    output logic                        o_error_fixed,
    output logic                        o_bad_syndrome
);
    import hsc_pkg::*;

    logic [LEN_W-1:0][CODE_W-1:0] term;
    logic [LEN_W-1:0]             syn;
    logic                         is_dec;
    logic                         fixed;
    logic                         bad;
    logic [CODE_W-1:0]            n_code;

    logic                         r_valid;
    logic [CODE_W-1:0]            r_code;
    logic [LEN_W-1:0]             r_syn;
    logic                         r_fixed;
    logic                         r_bad;

    // syndrome bit b: parity of set positions whose index has bit b set
    always_comb begin
        for (int b = 0; b < LEN_W; b++) begin
            for (int k = 0; k < CODE_W; k++) begin
                term[b][k] = i_word[k] && ((((k + 1) >> b) & 1) == 1);
            end
            syn[b] = ^term[b];
        end
    end

    assign is_dec = (i_ctl.func == FUNC_DECODE);
    assign fixed  = is_dec && (syn != '0) && (syn <= i_ctl.code_len);
    assign bad    = is_dec && (syn > i_ctl.code_len);

    for (genvar k = 0; k < CODE_W; k++) begin : g_out
        localparam int POS = k + 1;
        localparam bit IS_P2 = (POS & (POS - 1)) == 0;
        if (IS_P2) begin : g_par
            // parity slot: syndrome of the laid-out data gives its value
            assign n_code[k] = is_dec
                ? (i_word[k] ^ (fixed && (syn == LEN_W'(POS))))
                : (i_word[k] | (syn[$clog2(POS)] && (LEN_W'(POS) <= i_ctl.code_len)));
        end else begin : g_dat
            assign n_code[k] = i_word[k] ^ (fixed && (syn == LEN_W'(POS)));
        end
    end

    assign o_q_pop = !i_q_empty && (!r_valid || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_code  <= n_code;
            r_syn   <= is_dec ? syn : '0;
            r_fixed <= fixed;
            r_bad   <= bad;
        end
    end

    assign o_empty        = !r_valid;
    assign o_code_out     = r_code;
    assign o_syndrome     = r_syn;
    assign o_error_fixed  = r_fixed;
    assign o_bad_syndrome = r_bad;

endmodule
